// ----- hdl/pfr2l_pkg.sv -----
// Package for the two-list page frame replacement block.
// Holds default sizes, list selectors and configuration register indexes.
// No dependencies.
package pfr2l_pkg;

    localparam int VIRTUAL_PAGES_DEF = 65536;
    localparam int FRAME_COUNT_DEF   = 4096;
    localparam int EVICT_SCAN_DEF    = 128;
    localparam int DEMOTE_SCAN_DEF   = 64;

    // Fixed field widths of the stream payloads
    localparam int PAGE_FIELD_W  = 16;
    localparam int FRAME_FIELD_W = 12;
    localparam int CFG_DATA_W    = 13;
    localparam int RESULT_W      = 32;

    // Hard limit on managed frames, independent of the storage size
    localparam int CAP_LIMIT = 4096;

    // List selectors
    localparam logic LIST_INACTIVE = 1'b0;
    localparam logic LIST_ACTIVE   = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CACHE_PAGES = 1'b0;
    localparam logic CFG_LRU_MODE    = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CACHE_PAGES_RST = 13'd4096;

endpackage

// ----- hdl/page_frame_replacement_two_list.sv -----
// Top level of the two-list (active / inactive) page frame replacement block.
// One sequencer walks the linked lists held in on-chip memories.
// Depends on pfr2l_pkg.

// Each transfer on the input stream is one virtual page access; each produces
// exactly one result transfer {hit, frame, evicted_valid, evicted_page,
// counted_miss}. After reset the block runs a clearing pass over the whole
// page table (VIRTUAL_PAGES entries, 65536 by default) and accepts no access
// until it ends; configuration writes are taken at any time. Accesses are
// handled one at a time by a single list sequencer with one write and one
// read port per memory. A hit goes from lookup and decode to output; a miss
// that fills a free frame goes on to the fill and a push onto the inactive
// head; a miss with eviction first scans up to EVICT_SCAN nodes from the
// inactive tail (if any), then may run the rebalancing scan over up to
// DEMOTE_SCAN nodes, before the fill. Each node moved is walked as one read,
// then an unlink and a push. The input is ready again as soon as the result
// sits in the output register. VIRTUAL_PAGES and FRAME_COUNT must be powers
// of two; page numbers are reduced modulo VIRTUAL_PAGES. At most 4096 frames
// are managed; the inactive/active balance ratio is one: outside LRU mode,
// rebalancing starts when the inactive list holds fewer frames than active.
module page_frame_replacement_two_list
    import pfr2l_pkg::*;
#(
    parameter int VIRTUAL_PAGES = VIRTUAL_PAGES_DEF,
    parameter int FRAME_COUNT   = FRAME_COUNT_DEF,
    parameter int EVICT_SCAN    = EVICT_SCAN_DEF,
    parameter int DEMOTE_SCAN   = DEMOTE_SCAN_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // s_tdata: vpage[15:0]
    input  logic [PAGE_FIELD_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // m_tdata: hit[0], frame[12:1], evicted_valid[13], evicted_page[29:14],
    //          counted_miss[30], zero[31]
    output logic [RESULT_W-1:0]     m_tdata
);

    localparam int VPW = $clog2(VIRTUAL_PAGES);
    localparam int FW  = $clog2(FRAME_COUNT);
    localparam int LW  = FW + 1;                 // frame link with "none" flag
    localparam int CW  = FW + 1;                 // counts up to FRAME_COUNT
    localparam int SCAN_MAX = (EVICT_SCAN > DEMOTE_SCAN) ? EVICT_SCAN : DEMOTE_SCAN;
    localparam int SCW = $clog2(SCAN_MAX + 1);
    localparam int CAP_LIM = (FRAME_COUNT < CAP_LIMIT) ? FRAME_COUNT : CAP_LIMIT;
    localparam logic [LW-1:0] NONE = {1'b1, {FW{1'b0}}};

    // Sequencer states
    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_LOOK   = 5'd2;
    localparam logic [4:0] S_DEC    = 5'd3;
    localparam logic [4:0] S_E_RD   = 5'd4;
    localparam logic [4:0] S_E_EV   = 5'd5;
    localparam logic [4:0] S_E_NEXT = 5'd6;
    localparam logic [4:0] S_V_RD   = 5'd7;
    localparam logic [4:0] S_V_EV   = 5'd8;
    localparam logic [4:0] S_V_DONE = 5'd9;
    localparam logic [4:0] S_D_RD   = 5'd10;
    localparam logic [4:0] S_D_EV   = 5'd11;
    localparam logic [4:0] S_D_NEXT = 5'd12;
    localparam logic [4:0] S_UNL    = 5'd13;
    localparam logic [4:0] S_P1     = 5'd14;
    localparam logic [4:0] S_P2     = 5'd15;
    localparam logic [4:0] S_FILL   = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    // Memories: page table, frame table, referenced bits, list links
    logic [FW:0]    p2f_mem  [VIRTUAL_PAGES];   // {valid, frame}
    logic [VPW-1:0] f2p_mem  [FRAME_COUNT];
    logic           ref_mem  [FRAME_COUNT];
    logic [LW-1:0]  prev_mem [FRAME_COUNT];
    logic [LW-1:0]  next_mem [FRAME_COUNT];

    logic [FW:0]    p2f_rd;
    logic [VPW-1:0] f2p_rd;
    logic           ref_rd;
    logic [LW-1:0]  prev_rd, next_rd;

    logic           p2f_we, f2p_we, ref_we, prev_we, next_we;
    logic [VPW-1:0] p2f_wa;
    logic [FW-1:0]  f2p_wa, ref_wa, prev_wa, next_wa;
    logic [FW:0]    p2f_wd;
    logic [VPW-1:0] f2p_wd;
    logic           ref_wd;
    logic [LW-1:0]  prev_wd, next_wd;

    // Control and payload registers
    logic [4:0]     state_reg, state_next;
    logic [4:0]     cont_reg, cont_next;
    logic [VPW-1:0] page_reg, page_next;
    logic [FW-1:0]  frame_reg, frame_next;
    logic [LW-1:0]  cur_reg, cur_next;
    logic [LW-1:0]  p_reg, p_next;
    logic [LW-1:0]  n_reg, n_next;
    logic [SCW-1:0] i_reg, i_next;
    logic           ul_reg, ul_next;
    logic           pu_reg, pu_next;
    logic           do_push_reg, do_push_next;
    logic           hit_reg, hit_next;
    logic           ev_valid_reg, ev_valid_next;
    logic [VPW-1:0] ev_page_reg, ev_page_next;
    logic           counted_reg, counted_next;
    logic [CW-1:0]  frames_used_reg, frames_used_next;
    logic           warm_reg, warm_next;
    logic [CW-1:0]  cnt_reg [2];
    logic [CW-1:0]  cnt_next [2];
    logic [LW-1:0]  head_reg [2];
    logic [LW-1:0]  head_next [2];
    logic [LW-1:0]  tail_reg [2];
    logic [LW-1:0]  tail_next [2];
    logic [CFG_DATA_W-1:0] cache_pages_reg;
    logic           lru_reg;
    logic [VPW-1:0] clr_reg, clr_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [RESULT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [CW-1:0]  cap;
    logic [31:0]    cap_wide;
    logic [SCW-1:0] i_inc;

    // Effective cache size: zero acts as one, saturate at the frame limit
    always_comb
    begin
        if (cache_pages_reg == '0)
        begin
            cap_wide = 32'd1;
        end
        else if (32'(cache_pages_reg) > CAP_LIM)
        begin
            cap_wide = CAP_LIM;
        end
        else
        begin
            cap_wide = 32'(cache_pages_reg);
        end
    end
    assign cap   = CW'(cap_wide);
    assign i_inc = i_reg + SCW'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration writes, taken at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_pages_reg <= CACHE_PAGES_RST;
            lru_reg         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CACHE_PAGES: cache_pages_reg <= cfg_data;
                CFG_LRU_MODE:    lru_reg         <= cfg_data[0];
                default:         lru_reg         <= lru_reg;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cont_next        = cont_reg;
        page_next        = page_reg;
        frame_next       = frame_reg;
        cur_next         = cur_reg;
        p_next           = p_reg;
        n_next           = n_reg;
        i_next           = i_reg;
        ul_next          = ul_reg;
        pu_next          = pu_reg;
        do_push_next     = do_push_reg;
        hit_next         = hit_reg;
        ev_valid_next    = ev_valid_reg;
        ev_page_next     = ev_page_reg;
        counted_next     = counted_reg;
        frames_used_next = frames_used_reg;
        warm_next        = warm_reg;
        cnt_next         = cnt_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        clr_next         = clr_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        p2f_we  = 1'b0;  p2f_wa  = page_reg;           p2f_wd  = '0;
        f2p_we  = 1'b0;  f2p_wa  = frame_reg;          f2p_wd  = page_reg;
        ref_we  = 1'b0;  ref_wa  = cur_reg[FW-1:0];    ref_wd  = 1'b0;
        prev_we = 1'b0;  prev_wa = cur_reg[FW-1:0];    prev_wd = NONE;
        next_we = 1'b0;  next_wa = cur_reg[FW-1:0];    next_wd = NONE;

        // Drop the result once the sink takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                p2f_we = 1'b1;
                p2f_wa = clr_reg;
                if (32'(clr_reg) < FRAME_COUNT)
                begin
                    f2p_we = 1'b1;
                    f2p_wa = FW'(clr_reg);
                    f2p_wd = '0;
                    ref_we = 1'b1;
                    ref_wa = FW'(clr_reg);
                end
                clr_next = clr_reg + VPW'(1);
                if (clr_reg == VPW'(VIRTUAL_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    page_next  = VPW'(32'(s_tdata) & (VIRTUAL_PAGES - 1));
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                ev_valid_next = 1'b0;
                ev_page_next  = '0;
                if (p2f_rd[FW])
                begin
                    frame_next   = p2f_rd[FW-1:0];
                    ref_we       = 1'b1;
                    ref_wa       = p2f_rd[FW-1:0];
                    ref_wd       = 1'b1;
                    hit_next     = 1'b1;
                    counted_next = 1'b0;
                    state_next   = S_OUT;
                end
                else
                begin
                    hit_next = 1'b0;
                    if (frames_used_reg < cap)
                    begin
                        frame_next       = frames_used_reg[FW-1:0];
                        frames_used_next = frames_used_reg + CW'(1);
                        state_next       = S_FILL;
                    end
                    else if (!tail_reg[LIST_INACTIVE][FW])
                    begin
                        i_next     = '0;
                        cur_next   = tail_reg[LIST_INACTIVE];
                        state_next = S_E_RD;
                    end
                    else
                    begin
                        cur_next   = tail_reg[LIST_ACTIVE];
                        ul_next    = LIST_ACTIVE;
                        state_next = S_V_RD;
                    end
                end
            end
            S_E_RD:
            begin
                state_next = S_E_EV;
            end
            S_E_EV:
            begin
                p_next  = prev_rd;
                n_next  = next_rd;
                ul_next = LIST_INACTIVE;
                if (ref_rd)
                begin
                    // Second chance: clear and move to a list head
                    ref_we       = 1'b1;
                    do_push_next = 1'b1;
                    pu_next      = lru_reg ? LIST_INACTIVE : LIST_ACTIVE;
                    cont_next    = S_E_NEXT;
                end
                else
                begin
                    frame_next   = cur_reg[FW-1:0];
                    ev_page_next = f2p_rd;
                    do_push_next = 1'b0;
                    cont_next    = S_V_DONE;
                end
                state_next = S_UNL;
            end
            S_E_NEXT:
            begin
                i_next   = i_inc;
                cur_next = p_reg;
                if (32'(i_inc) < EVICT_SCAN && !p_reg[FW])
                begin
                    state_next = S_E_RD;
                end
                else
                begin
                    // Fruitless scan: take whichever tail is left
                    if (!tail_reg[LIST_INACTIVE][FW])
                    begin
                        cur_next = tail_reg[LIST_INACTIVE];
                        ul_next  = LIST_INACTIVE;
                    end
                    else
                    begin
                        cur_next = tail_reg[LIST_ACTIVE];
                        ul_next  = LIST_ACTIVE;
                    end
                    state_next = S_V_RD;
                end
            end
            S_V_RD:
            begin
                state_next = S_V_EV;
            end
            S_V_EV:
            begin
                p_next       = prev_rd;
                n_next       = next_rd;
                frame_next   = cur_reg[FW-1:0];
                ev_page_next = f2p_rd;
                do_push_next = 1'b0;
                cont_next    = S_V_DONE;
                state_next   = S_UNL;
            end
            S_V_DONE:
            begin
                // Unmap the evicted page, then rebalance if inactive runs low (not in LRU mode)
                ev_valid_next = 1'b1;
                p2f_we        = 1'b1;
                p2f_wa        = ev_page_reg;
                p2f_wd        = '0;
                if (!lru_reg && (cnt_reg[LIST_INACTIVE] < cnt_reg[LIST_ACTIVE])
                    && !tail_reg[LIST_ACTIVE][FW])
                begin
                    i_next     = '0;
                    cur_next   = tail_reg[LIST_ACTIVE];
                    state_next = S_D_RD;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_D_RD:
            begin
                state_next = S_D_EV;
            end
            S_D_EV:
            begin
                p_next       = prev_rd;
                n_next       = next_rd;
                ul_next      = LIST_ACTIVE;
                do_push_next = 1'b1;
                pu_next      = ref_rd ? LIST_ACTIVE : LIST_INACTIVE;
                ref_we       = ref_rd;
                cont_next    = S_D_NEXT;
                state_next   = S_UNL;
            end
            S_D_NEXT:
            begin
                i_next   = i_inc;
                cur_next = p_reg;
                if (32'(i_inc) < DEMOTE_SCAN && !p_reg[FW])
                begin
                    state_next = S_D_RD;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_UNL:
            begin
                if (!p_reg[FW])
                begin
                    next_we = 1'b1;
                    next_wa = p_reg[FW-1:0];
                    next_wd = n_reg;
                end
                else
                begin
                    head_next[ul_reg] = n_reg;
                end
                if (!n_reg[FW])
                begin
                    prev_we = 1'b1;
                    prev_wa = n_reg[FW-1:0];
                    prev_wd = p_reg;
                end
                else
                begin
                    tail_next[ul_reg] = p_reg;
                end
                cnt_next[ul_reg] = cnt_reg[ul_reg] - CW'(1);
                state_next = do_push_reg ? S_P1 : cont_reg;
            end
            S_P1:
            begin
                next_we    = 1'b1;
                next_wd    = head_reg[pu_reg];
                prev_we    = 1'b1;
                prev_wd    = NONE;
                state_next = S_P2;
            end
            S_P2:
            begin
                if (!head_reg[pu_reg][FW])
                begin
                    prev_we = 1'b1;
                    prev_wa = head_reg[pu_reg][FW-1:0];
                    prev_wd = cur_reg;
                end
                else
                begin
                    tail_next[pu_reg] = cur_reg;
                end
                head_next[pu_reg] = cur_reg;
                cnt_next[pu_reg]  = cnt_reg[pu_reg] + CW'(1);
                state_next        = cont_reg;
            end
            S_FILL:
            begin
                p2f_we = 1'b1;
                p2f_wd = {1'b1, frame_reg};
                f2p_we = 1'b1;
                ref_we = 1'b1;
                ref_wa = frame_reg;
                if (frames_used_reg <= cap && !warm_reg)
                begin
                    counted_next = 1'b0;
                    if (frames_used_reg == cap)
                    begin
                        warm_next = 1'b1;
                    end
                end
                else
                begin
                    counted_next = 1'b1;
                end
                cur_next   = {1'b0, frame_reg};
                pu_next    = LIST_INACTIVE;
                cont_next  = S_OUT;
                state_next = S_P1;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, counted_reg,
                                     PAGE_FIELD_W'(32'(ev_page_reg)), ev_valid_reg,
                                     FRAME_FIELD_W'(32'(frame_reg)), hit_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            cont_reg        <= S_OUT;
            i_reg           <= '0;
            ul_reg          <= LIST_INACTIVE;
            pu_reg          <= LIST_INACTIVE;
            do_push_reg     <= 1'b0;
            frames_used_reg <= '0;
            warm_reg        <= 1'b0;
            cnt_reg         <= '{default: '0};
            head_reg        <= '{default: NONE};
            tail_reg        <= '{default: NONE};
            clr_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cont_reg        <= cont_next;
            i_reg           <= i_next;
            ul_reg          <= ul_next;
            pu_reg          <= pu_next;
            do_push_reg     <= do_push_next;
            frames_used_reg <= frames_used_next;
            warm_reg        <= warm_next;
            cnt_reg         <= cnt_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            clr_reg         <= clr_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        frame_reg    <= frame_next;
        cur_reg      <= cur_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        hit_reg      <= hit_next;
        ev_valid_reg <= ev_valid_next;
        ev_page_reg  <= ev_page_next;
        counted_reg  <= counted_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Memory ports: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (p2f_we)
        begin
            p2f_mem[p2f_wa] <= p2f_wd;
        end
        p2f_rd <= p2f_mem[page_reg];
    end

    always_ff @(posedge clk)
    begin
        if (f2p_we)
        begin
            f2p_mem[f2p_wa] <= f2p_wd;
        end
        f2p_rd <= f2p_mem[cur_reg[FW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_wa] <= ref_wd;
        end
        ref_rd <= ref_mem[cur_reg[FW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_rd <= prev_mem[cur_reg[FW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd <= next_mem[cur_reg[FW-1:0]];
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while the sequencer is busy");

    a_counts_match_used: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |->
        ({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]}) == {1'b0, frames_used_reg})
        else $error("list counts disagree with frames in use");

    a_inactive_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |->
        (head_reg[LIST_INACTIVE][FW] == (cnt_reg[LIST_INACTIVE] == '0)))
        else $error("inactive head disagrees with its count");

    a_active_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |->
        (tail_reg[LIST_ACTIVE][FW] == (cnt_reg[LIST_ACTIVE] == '0)))
        else $error("active tail disagrees with its count");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(frames_used_reg) <= FRAME_COUNT)
        else $error("frames in use beyond frame storage");
`endif

endmodule
